@@ rtl/core/tmhq_pkg.sv @@
// Package: shared types, constants and command codes of the timer heap queue
`default_nettype none
package tmhq_pkg;
   localparam int HeapDepth = 64;
   localparam int NumIds    = 64;
   localparam int TimeWidth = 32;
   localparam int IdWidth   = 6;
   localparam int AddrWidth = $clog2(HeapDepth);
   localparam int CntWidth  = $clog2(HeapDepth + 1);

   typedef enum logic [2:0] {
      CMD_ATTACH  = 3'd0,
      CMD_RESCHED = 3'd1,
      CMD_DETACH  = 3'd2,
      CMD_POLL    = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ALREADY = 2'd1,
      ST_NOT_REG = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]           cmd;
      logic [IdWidth-1:0]   entry_id;
      logic [TimeWidth-1:0] deadline;
      logic [TimeWidth-1:0] now_tick;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic                 due_valid;
      logic [IdWidth-1:0]   due_id;
      logic [TimeWidth-1:0] due_deadline;
      logic [CntWidth-1:0]  occupancy;
   } rsp_type;

   // one heap slot
   typedef struct packed {
      logic [IdWidth-1:0]   id;
      logic [TimeWidth-1:0] dl;
   } slot_type;

   // memory port bundle from sequencer to heap store
   typedef struct packed {
      logic                 rd_en;
      logic [AddrWidth-1:0] rd_addr;
      logic                 wr_en;
      logic [AddrWidth-1:0] wr_addr;
      slot_type             wr_data;
   } mem_ctl_type;
endpackage
`default_nettype wire

@@ rtl/core/tmhq_heap_ram.sv @@
// Heap store: slot memory, one write and one registered read per cycle
`default_nettype none
module tmhq_heap_ram (
   input  wire logic                 clock,
   input  wire tmhq_pkg::mem_ctl_type ctl,
   output tmhq_pkg::slot_type        rd_data
);
   tmhq_pkg::slot_type mem [tmhq_pkg::HeapDepth];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data <= mem[ctl.rd_addr];
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/tmhq_seq.sv @@
// Command sequencer: flags, count and the sift walks over the heap store
`default_nettype none
module tmhq_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire tmhq_pkg::req_type     req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output tmhq_pkg::rsp_type          rsp_data,
   output tmhq_pkg::mem_ctl_type      mem_ctl,
   input  wire tmhq_pkg::slot_type    mem_rd
);
   localparam int AW = tmhq_pkg::AddrWidth;
   localparam int CW = tmhq_pkg::CntWidth;
   localparam int TW = tmhq_pkg::TimeWidth;
   localparam int IW = tmhq_pkg::IdWidth;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_SRCH  = 11'b00000000010, // detach: scan for id
      S_SRCHW = 11'b00000000100,
      S_LAST  = 11'b00000001000, // read last slot
      S_LASTW = 11'b00000010000,
      S_UPR   = 11'b00000100000, // read parent
      S_UPW   = 11'b00001000000,
      S_DNL   = 11'b00010000000, // read left child
      S_DNR   = 11'b00100000000, // read right child
      S_DNC   = 11'b01000000000, // compare children
      S_RSP   = 11'b10000000000
   } state_type;

   state_type             st_ff, st_in;
   logic [tmhq_pkg::NumIds-1:0] flags_ff, flags_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         pos_ff, pos_in;   // hole position
   logic [CW-1:0]         scan_ff, scan_in; // search index
   tmhq_pkg::slot_type    mv_ff, mv_in;     // moving entry
   tmhq_pkg::slot_type    lc_ff, lc_in;     // left child
   tmhq_pkg::req_type     req_ff, req_in;
   tmhq_pkg::rsp_type     rsp_ff, rsp_in;
   logic                  rv_ff, rv_in;
   // first step of a detach sift up may turn into a sift down
   logic                  first_up_ff, first_up_in;
   logic                  dnc_right;

   logic [CW-1:0] lidx, ridx;
   logic [AW-1:0] par;
   logic [TW-1:0] never;

   assign never = '1;
   assign par   = AW'((pos_ff - AW'(1)) >> 1);
   assign lidx  = CW'({pos_ff, 1'b1});
   assign ridx  = lidx + CW'(1);
   assign dnc_right = (ridx < cnt_ff) && (lc_ff.dl > mem_rd.dl);

   assign req_ready = (st_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      st_in = st_ff; flags_in = flags_ff; cnt_in = cnt_ff; pos_in = pos_ff;
      scan_in = scan_ff; mv_in = mv_ff; lc_in = lc_ff;
      req_in = req_ff; rsp_in = rsp_ff; rv_in = rv_ff;
      mem_ctl = '0;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      unique case (st_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               req_in = req_data;
               rsp_in = '0;
               rsp_in.status = tmhq_pkg::ST_OK;
               st_in = S_RSP;
               unique case (req_data.cmd)
                  tmhq_pkg::CMD_ATTACH, tmhq_pkg::CMD_RESCHED: begin
                     if ((req_data.cmd == tmhq_pkg::CMD_ATTACH)
                         && flags_ff[req_data.entry_id]) begin
                        rsp_in.status = tmhq_pkg::ST_ALREADY;
                     end else if ((req_data.cmd == tmhq_pkg::CMD_RESCHED)
                                  && !flags_ff[req_data.entry_id]) begin
                        rsp_in.status = tmhq_pkg::ST_NOT_REG;
                     end else if (req_data.deadline == never) begin
                        flags_in[req_data.entry_id] = 1'b1;
                     end else if (cnt_ff >= CW'(tmhq_pkg::HeapDepth)) begin
                        rsp_in.status = tmhq_pkg::ST_FULL;
                     end else begin
                        flags_in[req_data.entry_id] = 1'b1;
                        mv_in  = '{id: req_data.entry_id, dl: req_data.deadline};
                        pos_in = AW'(cnt_ff);
                        cnt_in = cnt_ff + CW'(1);
                        st_in  = S_UPR;
                     end
                  end
                  tmhq_pkg::CMD_DETACH: begin
                     if (!flags_ff[req_data.entry_id]) begin
                        rsp_in.status = tmhq_pkg::ST_NOT_REG;
                     end else begin
                        flags_in[req_data.entry_id] = 1'b0;
                        scan_in = '0;
                        st_in = S_SRCH;
                     end
                  end
                  tmhq_pkg::CMD_POLL: begin
                     if (cnt_ff != '0) begin
                        mem_ctl.rd_en = 1'b1;
                        mem_ctl.rd_addr = '0;
                        scan_in = '0;
                        st_in = S_SRCHW;
                     end
                  end
                  tmhq_pkg::CMD_CLEAR: begin
                     cnt_in = '0;
                     flags_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_SRCH: begin
            if (scan_ff >= cnt_ff) begin
               st_in = S_RSP;
            end else begin
               mem_ctl.rd_en = 1'b1;
               mem_ctl.rd_addr = AW'(scan_ff);
               st_in = S_SRCHW;
            end
         end
         S_SRCHW: begin
            // slot at scan_ff is on the read port
            if (req_ff.cmd == tmhq_pkg::CMD_POLL) begin
               if (mem_rd.dl <= req_ff.now_tick) begin
                  rsp_in.due_valid = 1'b1;
                  rsp_in.due_id = mem_rd.id;
                  rsp_in.due_deadline = mem_rd.dl;
                  pos_in = '0;
                  st_in = S_LAST;
               end else begin
                  st_in = S_RSP;
               end
            end else if (mem_rd.id == req_ff.entry_id) begin
               pos_in = AW'(scan_ff);
               st_in = S_LAST;
            end else begin
               scan_in = scan_ff + CW'(1);
               st_in = S_SRCH;
            end
         end
         S_LAST: begin
            mem_ctl.rd_en = 1'b1;
            mem_ctl.rd_addr = AW'(cnt_ff - CW'(1));
            cnt_in = cnt_ff - CW'(1);
            st_in = S_LASTW;
         end
         S_LASTW: begin
            mv_in = mem_rd;
            if (CW'(pos_ff) == cnt_ff) begin
               st_in = S_RSP;
            end else if (pos_ff == '0) begin
               st_in = S_DNL;
            end else begin
               // parent test decides direction
               st_in = S_UPR;
            end
         end
         S_UPR: begin
            if (pos_ff == '0) begin
               mem_ctl.wr_en = 1'b1;
               mem_ctl.wr_addr = pos_ff;
               mem_ctl.wr_data = mv_ff;
               st_in = S_RSP;
            end else begin
               mem_ctl.rd_en = 1'b1;
               mem_ctl.rd_addr = par;
               st_in = S_UPW;
            end
         end
         S_UPW: begin
            if (mem_rd.dl > mv_ff.dl) begin
               mem_ctl.wr_en = 1'b1;
               mem_ctl.wr_addr = pos_ff;
               mem_ctl.wr_data = mem_rd;
               pos_in = par;
               st_in = S_UPR;
            end else if (req_ff.cmd != tmhq_pkg::CMD_DETACH || !first_up_ff) begin
               mem_ctl.wr_en = 1'b1;
               mem_ctl.wr_addr = pos_ff;
               mem_ctl.wr_data = mv_ff;
               st_in = S_RSP;
            end else begin
               st_in = S_DNL;
            end
         end
         S_DNL: begin
            if (lidx >= cnt_ff) begin
               mem_ctl.wr_en = 1'b1;
               mem_ctl.wr_addr = pos_ff;
               mem_ctl.wr_data = mv_ff;
               st_in = S_RSP;
            end else begin
               mem_ctl.rd_en = 1'b1;
               mem_ctl.rd_addr = AW'(lidx);
               st_in = S_DNR;
            end
         end
         S_DNR: begin
            lc_in = mem_rd;
            if (ridx < cnt_ff) begin
               mem_ctl.rd_en = 1'b1;
               mem_ctl.rd_addr = AW'(ridx);
            end
            st_in = S_DNC;
         end
         S_DNC: begin
            if (dnc_right) begin
               if (mv_ff.dl <= mem_rd.dl) begin
                  mem_ctl.wr_en = 1'b1;
                  mem_ctl.wr_addr = pos_ff;
                  mem_ctl.wr_data = mv_ff;
                  st_in = S_RSP;
               end else begin
                  mem_ctl.wr_en = 1'b1;
                  mem_ctl.wr_addr = pos_ff;
                  mem_ctl.wr_data = mem_rd;
                  pos_in = AW'(ridx);
                  st_in = S_DNL;
               end
            end else if (mv_ff.dl <= lc_ff.dl) begin
               mem_ctl.wr_en = 1'b1;
               mem_ctl.wr_addr = pos_ff;
               mem_ctl.wr_data = mv_ff;
               st_in = S_RSP;
            end else begin
               mem_ctl.wr_en = 1'b1;
               mem_ctl.wr_addr = pos_ff;
               mem_ctl.wr_data = lc_ff;
               pos_in = AW'(lidx);
               st_in = S_DNL;
            end
         end
         S_RSP: begin
            if (!rv_ff) begin
               rsp_in.occupancy = cnt_ff;
               rv_in = 1'b1;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   // mark the first parent test after the last slot is taken
   always_comb begin
      first_up_in = first_up_ff;
      if (st_ff == S_LASTW) begin
         first_up_in = 1'b1;
      end else if (st_ff == S_UPW || st_ff == S_IDLE) begin
         first_up_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         flags_ff <= '0;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
         first_up_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         flags_ff <= flags_in;
         cnt_ff <= cnt_in;
         rv_ff <= rv_in;
         first_up_ff <= first_up_in;
      end
      pos_ff <= pos_in;
      scan_ff <= scan_in;
      mv_ff <= mv_in;
      lc_ff <= lc_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

@@ rtl/core/timer_min_heap_queue_core.sv @@
// Top level: timer queue on a binary min-heap held in one slot memory
//   channel | direction | payload              | handshake
//   req     | in        | tmhq_pkg::req_type   | req_valid / req_ready
//   rsp     | out       | tmhq_pkg::rsp_type   | rsp_valid / rsp_ready
// One item at a time. Attach and reschedule climb the heap level by level;
// a pop or detach sifts down level by level, and a detach first scans the
// slots one by one while looking for the id, all on the single memory read
// port. Clear only resets the flags and the count. Reset clears the flags
// and the count at once; the slot memory needs no clearing. A stalled
// result holds req_ready low.
`default_nettype none
module timer_min_heap_queue_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tmhq_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tmhq_pkg::rsp_type      rsp_data
);
   tmhq_pkg::mem_ctl_type mem_ctl;
   tmhq_pkg::slot_type    mem_rd;

   tmhq_seq u_seq (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .mem_ctl(mem_ctl), .mem_rd(mem_rd)
   );

   tmhq_heap_ram u_ram (
      .clock(clock), .ctl(mem_ctl), .rd_data(mem_rd)
   );
endmodule
`default_nettype wire

@@ rtl/core/tmhq_checker.sv @@
// Port checker for the timer queue, bound to the top level
`default_nettype none
module tmhq_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire tmhq_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire tmhq_pkg::rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item taken while result pending");
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.occupancy <= tmhq_pkg::CntWidth'(tmhq_pkg::HeapDepth))
      else $error("occupancy out of range");
   a_due_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.due_valid |-> rsp_data.status == tmhq_pkg::ST_OK)
      else $error("pop with error status");
endmodule

bind timer_min_heap_queue_core tmhq_checker u_checker (.*);
`default_nettype wire

@@ test/timer_min_heap_queue_core_test.sv @@
// Testbench: random and directed command items against a heap timer queue predictor
`timescale 1ns / 1ps
module timer_min_heap_queue_core_test;
   localparam int GapLimit = 20000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   tmhq_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   tmhq_pkg::rsp_type rsp_data;

   timer_min_heap_queue_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [tmhq_pkg::IdWidth-1:0]   heap_ids [tmhq_pkg::HeapDepth];
   logic [tmhq_pkg::TimeWidth-1:0] heap_dls [tmhq_pkg::HeapDepth];
   int                             heap_cnt = 0;
   bit                             reg_flag [tmhq_pkg::NumIds];

   tmhq_pkg::req_type pending_items [$];
   tmhq_pkg::rsp_type expected_rsps [$];
   int      mismatches = 0;
   int      idle_cycles = 0;
   bit      stim_done = 1'b0;
   bit      hold_sender = 1'b0;
   int      send_gap = 0;
   int      recv_gap = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // append one item to the stimulus queue
   function automatic void add_item(tmhq_pkg::req_type q);
      pending_items.insert(pending_items.size(), q);
   endfunction

   function automatic void heap_sift_up(int pos, logic [tmhq_pkg::IdWidth-1:0] id,
                                        logic [tmhq_pkg::TimeWidth-1:0] dl);
      int par;
      while (pos != 0) begin
         par = (pos - 1) / 2;
         if (heap_dls[par] <= dl) break;
         heap_ids[pos] = heap_ids[par];
         heap_dls[pos] = heap_dls[par];
         pos = par;
      end
      heap_ids[pos] = id;
      heap_dls[pos] = dl;
   endfunction

   function automatic void heap_sift_down(int pos, logic [tmhq_pkg::IdWidth-1:0] id,
                                          logic [tmhq_pkg::TimeWidth-1:0] dl);
      int c;
      c = 2 * pos + 1;
      while (c < heap_cnt) begin
         if (c + 1 < heap_cnt && heap_dls[c] > heap_dls[c+1]) c++;
         if (dl <= heap_dls[c]) break;
         heap_ids[pos] = heap_ids[c];
         heap_dls[pos] = heap_dls[c];
         pos = c;
         c = 2 * pos + 1;
      end
      heap_ids[pos] = id;
      heap_dls[pos] = dl;
   endfunction

   function automatic tmhq_pkg::status_type heap_push(
         logic [tmhq_pkg::IdWidth-1:0] id, logic [tmhq_pkg::TimeWidth-1:0] dl);
      if (dl == '1) return tmhq_pkg::ST_OK;
      if (heap_cnt >= tmhq_pkg::HeapDepth) return tmhq_pkg::ST_FULL;
      heap_cnt++;
      heap_sift_up(heap_cnt - 1, id, dl);
      return tmhq_pkg::ST_OK;
   endfunction

   function automatic void heap_remove(int pos);
      logic [tmhq_pkg::IdWidth-1:0]   lid;
      logic [tmhq_pkg::TimeWidth-1:0] ldl;
      lid = heap_ids[heap_cnt-1];
      ldl = heap_dls[heap_cnt-1];
      heap_cnt--;
      if (pos == heap_cnt) return;
      if (pos != 0 && heap_dls[(pos-1)/2] > ldl) heap_sift_up(pos, lid, ldl);
      else heap_sift_down(pos, lid, ldl);
   endfunction

   // work out the response to one accepted command
   function automatic tmhq_pkg::rsp_type timer_queue_step(tmhq_pkg::req_type rq);
      tmhq_pkg::rsp_type    r;
      tmhq_pkg::status_type st;
      r = '0;
      st = tmhq_pkg::ST_OK;
      case (rq.cmd)
         tmhq_pkg::CMD_ATTACH: begin
            if (reg_flag[rq.entry_id]) st = tmhq_pkg::ST_ALREADY;
            else begin
               st = heap_push(rq.entry_id, rq.deadline);
               if (st == tmhq_pkg::ST_OK) reg_flag[rq.entry_id] = 1'b1;
            end
         end
         tmhq_pkg::CMD_RESCHED: begin
            if (!reg_flag[rq.entry_id]) st = tmhq_pkg::ST_NOT_REG;
            else st = heap_push(rq.entry_id, rq.deadline);
         end
         tmhq_pkg::CMD_DETACH: begin
            if (!reg_flag[rq.entry_id]) st = tmhq_pkg::ST_NOT_REG;
            else begin
               reg_flag[rq.entry_id] = 1'b0;
               for (int i = 0; i < heap_cnt; i++) begin
                  if (heap_ids[i] == rq.entry_id) begin
                     heap_remove(i);
                     break;
                  end
               end
            end
         end
         tmhq_pkg::CMD_POLL: begin
            if (heap_cnt != 0 && heap_dls[0] <= rq.now_tick) begin
               r.due_valid = 1'b1;
               r.due_id = heap_ids[0];
               r.due_deadline = heap_dls[0];
               heap_remove(0);
            end
         end
         tmhq_pkg::CMD_CLEAR: begin
            heap_cnt = 0;
            foreach (reg_flag[i]) reg_flag[i] = 1'b0;
         end
         default: ;
      endcase
      r.status = st;
      r.occupancy = heap_cnt[tmhq_pkg::CntWidth-1:0];
      return r;
   endfunction

   function automatic tmhq_pkg::req_type make_item(tmhq_pkg::cmd_type c, int id,
                                                   logic [31:0] dl, logic [31:0] nt);
      tmhq_pkg::req_type q;
      q.cmd = c;
      q.entry_id = id[tmhq_pkg::IdWidth-1:0];
      q.deadline = dl;
      q.now_tick = nt;
      return q;
   endfunction

   // deadlines mostly from a narrow window so ties and due pops are common
   function automatic logic [31:0] rand_deadline();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '1;
      if (r < 10) return $urandom();
      if (r < 13) return 32'hFFFF_FFFE;
      return $urandom_range(0, 200);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
      end else begin
         if (req_valid)
            expected_rsps.insert(expected_rsps.size(), timer_queue_step(req_data));
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0 && !hold_sender) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               tmhq_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (e.status !== rsp_data.status || e.due_valid !== rsp_data.due_valid
                   || e.due_id !== rsp_data.due_id
                   || e.due_deadline !== rsp_data.due_deadline
                   || e.occupancy !== rsp_data.occupancy) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p got %p", e, rsp_data);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles >= GapLimit) begin
         $display("timer_min_heap_queue_core regression: fail");
         $finish;
      end
   end

   initial begin
      int r, id;
      foreach (reg_flag[i]) reg_flag[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, refusals, never deadlines, empty poll
      add_item(make_item(tmhq_pkg::CMD_POLL, 0, 0, '1));
      add_item(make_item(tmhq_pkg::CMD_RESCHED, 5, 10, 0));
      add_item(make_item(tmhq_pkg::CMD_DETACH, 5, 0, 0));
      add_item(make_item(tmhq_pkg::CMD_ATTACH, 0, 0, 0));
      add_item(make_item(tmhq_pkg::CMD_ATTACH, 0, 7, 0));
      add_item(make_item(tmhq_pkg::CMD_ATTACH, 63, '1, 0));
      add_item(make_item(tmhq_pkg::CMD_ATTACH, 42, 32'hFFFF_FFFE, 0));
      add_item(make_item(tmhq_pkg::CMD_RESCHED, 63, 100, 0));
      add_item(make_item(tmhq_pkg::CMD_RESCHED, 0, 100, 0));
      add_item(make_item(tmhq_pkg::CMD_RESCHED, 0, '1, 0));
      add_item(make_item(tmhq_pkg::CMD_POLL, 0, 0, 50));
      add_item(make_item(tmhq_pkg::CMD_DETACH, 0, 0, 0));
      add_item(make_item(tmhq_pkg::CMD_DETACH, 21, 0, 0));
      add_item(make_item(tmhq_pkg::CMD_POLL, 0, '1, 32'hFFFF_FFFD));
      add_item(make_item(tmhq_pkg::CMD_POLL, 63, '1, '1));
      add_item(make_item(tmhq_pkg::CMD_POLL, 0, 0, '1));
      add_item(make_item(tmhq_pkg::CMD_CLEAR, 0, 0, 0));
      add_item(make_item(tmhq_pkg::CMD_POLL, 0, 0, '1));
      // fill the heap to the brim and beyond
      for (int i = 0; i < tmhq_pkg::HeapDepth; i++)
         add_item(make_item(tmhq_pkg::CMD_ATTACH, i, $urandom_range(0, 30), 0));
      add_item(make_item(tmhq_pkg::CMD_RESCHED, 3, 5, 0));
      add_item(make_item(tmhq_pkg::CMD_CLEAR, 0, 0, 0));
      add_item(make_item(tmhq_pkg::CMD_ATTACH, 9, 1, 0));
      add_item(make_item(tmhq_pkg::CMD_ATTACH, 9, 1, 0));

      // random commands, biased towards a busy heap
      for (int n = 0; n < 1200; n++) begin
         r = $urandom_range(0, 99);
         id = $urandom_range(0, 63);
         if (r < 30)
            add_item(make_item(tmhq_pkg::CMD_ATTACH, id, rand_deadline(), $urandom()));
         else if (r < 50)
            add_item(make_item(tmhq_pkg::CMD_RESCHED, id, rand_deadline(), $urandom()));
         else if (r < 65)
            add_item(make_item(tmhq_pkg::CMD_DETACH, id, $urandom(), $urandom()));
         else if (r < 98)
            add_item(make_item(tmhq_pkg::CMD_POLL, id, $urandom(),
               ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 220)));
         else if (r < 99)
            add_item(make_item(tmhq_pkg::CMD_CLEAR, id, $urandom(), $urandom()));
         else
            add_item(make_item(tmhq_pkg::cmd_type'($urandom_range(5, 7)), id,
                               $urandom(), $urandom()));
         // once, hold the sender until the queue of expectations drains
         if (n == 600) begin
            wait (pending_items.size() == 0 && !req_valid);
            hold_sender = 1'b1;
            wait (expected_rsps.size() == 0);
            @(posedge clock);
            hold_sender = 1'b0;
         end
      end

      wait (pending_items.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("timer_min_heap_queue_core regression: pass");
      else
         $display("timer_min_heap_queue_core regression: fail");
      $finish;
   end
endmodule
